// ===== rtl/core/sfp_pkg.sv =====
// Shared types, codes and constants of the sensor frame parser.
package sfp_pkg;

   localparam int ByteWidth    = 8;
   localparam int WordWidth    = 16;
   localparam int CountWidth   = 20;
   localparam int StatusWidth  = 3;
   localparam int CmdWidth     = 2;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth = 20;
   localparam int QueueDepth   = 2;

   localparam logic [ByteWidth-1:0] START_BYTE = 8'h3A;
   localparam logic [ByteWidth-1:0] ZERO_BYTE  = 8'h00;
   localparam logic [ByteWidth-1:0] CR_BYTE    = 8'h0D;
   localparam logic [ByteWidth-1:0] LF_BYTE    = 8'h0A;

   localparam logic [CountWidth-1:0] COUNT_MAX        = 20'hFFFFF;
   localparam logic [CountWidth-1:0] TIMEOUT_RESET    = 20'd200;
   localparam logic [ByteWidth-1:0]  DEVICE_ID_RESET  = 8'h01;

   // request command codes
   localparam logic [CmdWidth-1:0] CMD_START = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_BYTE  = 2'd1;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_TIMEOUT_LIMIT = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_DEVICE_ID     = 1'b1;

   // status codes
   localparam logic [StatusWidth-1:0] ST_OK       = 3'd0;
   localparam logic [StatusWidth-1:0] ST_TIMEOUT  = 3'd1;
   localparam logic [StatusWidth-1:0] ST_CHECKSUM = 3'd2;
   localparam logic [StatusWidth-1:0] ST_NO_CR    = 3'd3;
   localparam logic [StatusWidth-1:0] ST_NO_LF    = 3'd4;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   typedef enum logic [1:0] {
      OP_START,
      OP_BYTE,
      OP_TICK
   } op_type;

   typedef enum logic [3:0] {
      PH_HUNT,
      PH_ID,
      PH_ZERO,
      PH_CMD_LO,
      PH_CMD_HI,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_PAYLOAD,
      PH_SUM_LO,
      PH_SUM_HI,
      PH_CR,
      PH_LF
   } phase_type;

   typedef struct packed {
      op_type               op;
      logic [ByteWidth-1:0] data;
   } item_type;

   // front-to-back handshake
   typedef struct packed {
      logic     valid;
      item_type item;
   } item_link_type;

   typedef struct packed {
      logic                   kind;
      logic [ByteWidth-1:0]   payload_byte;
      logic [WordWidth-1:0]   payload_index;
      logic [StatusWidth-1:0] status;
      logic [WordWidth-1:0]   frame_command;
      logic [WordWidth-1:0]   frame_length;
   } result_type;

endpackage

// ===== rtl/core/sensor_frame_parser.sv =====
// Top level of the sensor frame parser: front decode, back parser, queues.
//
//   channel   direction  handshake            payload
//   req       in         req_push / req_full  req_cmd, req_rx_byte
//   rsp       out        rsp_pop / rsp_empty  rsp_kind .. rsp_frame_length
//   csr       in         csr_write_enable     csr_index, csr_write_data
//
// One word per clock in steady state; the back parser consumes one queued word
// per cycle while the result queue has room. An accepted word is registered in
// the input queue, parsed from its head into the result queue, then popped on rsp.
// Reset is synchronous: both queues empty, the timeout disarms, timeout_limit =
// 200, device_id = 1. A stalled consumer fills the result queue, stalling the
// back parser, which then fills the input queue and raises req_full.
module sensor_frame_parser
   import sfp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   // request words
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [CmdWidth-1:0]      req_cmd,
   input  logic [ByteWidth-1:0]     req_rx_byte,
   // result words
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic                     rsp_kind,
   output logic [ByteWidth-1:0]     rsp_payload_byte,
   output logic [WordWidth-1:0]     rsp_payload_index,
   output logic [StatusWidth-1:0]   rsp_status,
   output logic [WordWidth-1:0]     rsp_frame_command,
   output logic [WordWidth-1:0]     rsp_frame_length,
   // register writes
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   item_link_type link;
   logic          link_take;
   result_type    rsp;

   // front: command decode and input queue
   sfp_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_cmd     (req_cmd),
      .req_rx_byte (req_rx_byte),
      .link        (link),
      .link_take   (link_take)
   );

   // back: frame parser, timeout, registers and result queue
   sfp_back #(
      .DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .link             (link),
      .link_take        (link_take),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp              (rsp),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop)
   );

   assign rsp_kind          = rsp.kind;
   assign rsp_payload_byte  = rsp.payload_byte;
   assign rsp_payload_index = rsp.payload_index;
   assign rsp_status        = rsp.status;
   assign rsp_frame_command = rsp.frame_command;
   assign rsp_frame_length  = rsp.frame_length;

endmodule

// ===== rtl/core/sfp_queue.sv =====
// Small register-based first-in first-out queue.
module sfp_queue
   import sfp_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == FullCnt);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/sfp_front.sv =====
// Front end: takes request words, decodes the command and queues them.
module sfp_front
   import sfp_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [CmdWidth-1:0]  req_cmd,
   input  logic [ByteWidth-1:0] req_rx_byte,
   output item_link_type        link,
   input  logic                 link_take
);

   item_type   item_new;
   logic [$bits(item_type)-1:0] head_bits;
   logic       q_empty;

   // undefined command code behaves as an idle tick
   always_comb begin
      item_new.data = req_rx_byte;
      case (req_cmd)
         CMD_START: item_new.op = OP_START;
         CMD_BYTE:  item_new.op = OP_BYTE;
         default:   item_new.op = OP_TICK;
      endcase
   end

   sfp_queue #(
      .WIDTH ($bits(item_type)),
      .DEPTH (DEPTH)
   ) u_in_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (item_new),
      .full      (req_full),
      .pop       (link_take),
      .pop_data  (head_bits),
      .empty     (q_empty)
   );

   assign link.valid = !q_empty;
   assign link.item  = item_type'(head_bits);

endmodule

// ===== rtl/core/sfp_back.sv =====
// Back end: frame state machine, checksum, timeout and result queue.
module sfp_back
   import sfp_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  item_link_type            link,
   output logic                     link_take,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data,
   output result_type               rsp,
   output logic                     rsp_empty,
   input  logic                     rsp_pop
);

   phase_type              phase_ff, phase_in;
   logic [WordWidth-1:0]   command_ff, command_in;
   logic [WordWidth-1:0]   length_ff, length_in;
   logic [WordWidth-1:0]   count_ff, count_in;
   logic [WordWidth-1:0]   sum_ff, sum_in;
   logic [ByteWidth-1:0]   recv_lo_ff, recv_lo_in;
   logic [CountWidth-1:0]  tmo_count_ff, tmo_count_in;
   logic                   armed_ff, armed_in;
   logic [CountWidth-1:0]  tmo_limit_ff;
   logic [ByteWidth-1:0]   device_id_ff;

   logic                   out_full;
   logic                   is_start, live, timed_out, is_byte;
   logic [ByteWidth-1:0]   b;
   logic [WordWidth-1:0]   count_next, sum_plus, length_new;
   logic                   sum_bad;
   logic                   res_valid;
   result_type             res;
   logic [$bits(result_type)-1:0] rsp_bits;

   assign link_take  = link.valid && !out_full;
   assign b          = link.item.data;
   assign is_start   = link.item.op == OP_START;
   assign live       = armed_ff && !is_start;
   assign timed_out  = live && (tmo_count_ff > tmo_limit_ff);
   assign is_byte    = live && !timed_out && (link.item.op == OP_BYTE);
   assign count_next = count_ff + 1'b1;
   assign sum_plus   = sum_ff + WordWidth'(b);
   assign length_new = {b, length_ff[ByteWidth-1:0]};
   assign sum_bad    = {b, recv_lo_ff} != sum_ff;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_start || timed_out) begin
         phase_in = PH_HUNT;
      end else if (is_byte) begin
         case (phase_ff)
            PH_HUNT:    phase_in = (b == START_BYTE) ? PH_ID : PH_HUNT;
            PH_ID:      phase_in = (b == device_id_ff) ? PH_ZERO : PH_HUNT;
            PH_ZERO:    phase_in = (b == ZERO_BYTE) ? PH_CMD_LO : PH_HUNT;
            PH_CMD_LO:  phase_in = PH_CMD_HI;
            PH_CMD_HI:  phase_in = PH_LEN_LO;
            PH_LEN_LO:  phase_in = PH_LEN_HI;
            PH_LEN_HI:  phase_in = (length_new == '0) ? PH_SUM_LO : PH_PAYLOAD;
            PH_PAYLOAD: phase_in = (count_next == length_ff) ? PH_SUM_LO : PH_PAYLOAD;
            PH_SUM_LO:  phase_in = PH_SUM_HI;
            PH_SUM_HI:  phase_in = sum_bad ? PH_HUNT : PH_CR;
            PH_CR:      phase_in = (b == CR_BYTE) ? PH_LF : PH_HUNT;
            default:    phase_in = PH_HUNT;
         endcase
      end
   end

   // datapath updates and result
   always_comb begin
      command_in    = command_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      recv_lo_in    = recv_lo_ff;
      tmo_count_in  = tmo_count_ff;
      armed_in      = armed_ff;
      res_valid     = 1'b0;
      res           = '0;
      res.kind          = KIND_END;
      res.frame_command = command_ff;
      res.frame_length  = count_ff;

      if (is_start) begin
         command_in   = '0;
         length_in    = '0;
         count_in     = '0;
         sum_in       = '0;
         recv_lo_in   = '0;
         tmo_count_in = '0;
         armed_in     = 1'b1;
      end else if (timed_out) begin
         res_valid  = 1'b1;
         res.status = ST_TIMEOUT;
         armed_in   = 1'b0;
      end else if (live) begin
         if (tmo_count_ff != COUNT_MAX) begin
            tmo_count_in = tmo_count_ff + 1'b1;
         end
         if (is_byte) begin
            case (phase_ff)
               PH_ID: begin
                  sum_in = (b == device_id_ff) ? sum_plus : '0;
               end
               PH_ZERO: begin
                  sum_in = (b == ZERO_BYTE) ? sum_plus : '0;
               end
               PH_CMD_LO: begin
                  command_in = {command_ff[WordWidth-1:ByteWidth], b};
                  sum_in     = sum_plus;
               end
               PH_CMD_HI: begin
                  command_in = {b, command_ff[ByteWidth-1:0]};
                  sum_in     = sum_plus;
               end
               PH_LEN_LO: begin
                  length_in = {length_ff[WordWidth-1:ByteWidth], b};
                  sum_in    = sum_plus;
               end
               PH_LEN_HI: begin
                  length_in = length_new;
                  sum_in    = sum_plus;
               end
               PH_PAYLOAD: begin
                  res_valid         = 1'b1;
                  res.kind          = KIND_PAYLOAD;
                  res.payload_byte  = b;
                  res.payload_index = count_ff;
                  res.frame_command = '0;
                  res.frame_length  = '0;
                  count_in          = count_next;
                  sum_in            = sum_plus;
               end
               PH_SUM_LO: begin
                  recv_lo_in = b;
               end
               PH_SUM_HI: begin
                  if (sum_bad) begin
                     res_valid  = 1'b1;
                     res.status = ST_CHECKSUM;
                     armed_in   = 1'b0;
                  end
               end
               PH_CR: begin
                  if (b != CR_BYTE) begin
                     res_valid  = 1'b1;
                     res.status = ST_NO_CR;
                     armed_in   = 1'b0;
                  end
               end
               PH_LF: begin
                  res_valid  = 1'b1;
                  res.status = (b == LF_BYTE) ? ST_OK : ST_NO_LF;
                  armed_in   = 1'b0;
               end
               default: begin
                  sum_in = sum_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         command_ff   <= '0;
         length_ff    <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         recv_lo_ff   <= '0;
         tmo_count_ff <= '0;
         armed_ff     <= 1'b0;
      end else if (link_take) begin
         phase_ff     <= phase_in;
         command_ff   <= command_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         recv_lo_ff   <= recv_lo_in;
         tmo_count_ff <= tmo_count_in;
         armed_ff     <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_limit_ff <= TIMEOUT_RESET;
         device_id_ff <= DEVICE_ID_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TIMEOUT_LIMIT: tmo_limit_ff <= csr_write_data;
            CSR_DEVICE_ID:     device_id_ff <= csr_write_data[ByteWidth-1:0];
            default:           tmo_limit_ff <= tmo_limit_ff;
         endcase
      end
   end

   sfp_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (link_take && res_valid),
      .push_data (res),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp = result_type'(rsp_bits);

endmodule

// ===== sim/sfp_frame_checker.sv =====
// Channel monitor for the sensor frame parser: predicts result words and compares them.
module sfp_frame_checker
   import sfp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  logic                     req_full,
   input  logic [CmdWidth-1:0]      req_cmd,
   input  logic [ByteWidth-1:0]     req_rx_byte,
   input  logic                     rsp_empty,
   input  logic                     rsp_pop,
   input  logic                     rsp_kind,
   input  logic [ByteWidth-1:0]     rsp_payload_byte,
   input  logic [WordWidth-1:0]     rsp_payload_index,
   input  logic [StatusWidth-1:0]   rsp_status,
   input  logic [WordWidth-1:0]     rsp_frame_command,
   input  logic [WordWidth-1:0]     rsp_frame_length,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data,
   output int                       outstanding,
   output int                       failures
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [CountWidth-1:0] limit_reg;
   logic [ByteWidth-1:0]  id_reg;

   phase_type             phase;
   logic [WordWidth-1:0]  command_word;
   logic [WordWidth-1:0]  length_word;
   logic [WordWidth-1:0]  byte_count;
   logic [WordWidth-1:0]  sum_acc;
   logic [WordWidth-1:0]  sum_rx;
   logic [CountWidth-1:0] item_count;
   logic                  armed;

   result_type expected_words[$];

   task automatic clear_frame();
      phase        = PH_HUNT;
      command_word = '0;
      length_word  = '0;
      byte_count   = '0;
      sum_acc      = '0;
      sum_rx       = '0;
   endtask

   task automatic accumulate(input logic [ByteWidth-1:0] b);
      sum_acc = sum_acc + {8'h00, b};
   endtask

   // end or error word; disarms and drops back to hunting
   task automatic close_frame(input logic [StatusWidth-1:0] status);
      result_type r;
      r               = '0;
      r.kind          = KIND_END;
      r.status        = status;
      r.frame_command = command_word;
      r.frame_length  = byte_count;
      expected_words.push_back(r);
      armed = 1'b0;
      phase = PH_HUNT;
   endtask

   task automatic advance_parser(input logic [CmdWidth-1:0] cmd, input logic [ByteWidth-1:0] b);
      result_type r;
      if (cmd == CMD_START) begin
         clear_frame();
         item_count = '0;
         armed      = 1'b1;
      end else if (armed) begin
         if (item_count > limit_reg) begin
            close_frame(ST_TIMEOUT);
         end else begin
            if (item_count != COUNT_MAX) item_count = item_count + 1'b1;
            if (cmd == CMD_BYTE) begin
               case (phase)
                  PH_HUNT: begin
                     if (b == START_BYTE) phase = PH_ID;
                  end
                  PH_ID: begin
                     if (b == id_reg) begin
                        accumulate(b);
                        phase = PH_ZERO;
                     end else begin
                        phase   = PH_HUNT;
                        sum_acc = '0;
                     end
                  end
                  PH_ZERO: begin
                     if (b == ZERO_BYTE) begin
                        accumulate(b);
                        phase = PH_CMD_LO;
                     end else begin
                        phase   = PH_HUNT;
                        sum_acc = '0;
                     end
                  end
                  PH_CMD_LO: begin
                     command_word[7:0] = b;
                     accumulate(b);
                     phase = PH_CMD_HI;
                  end
                  PH_CMD_HI: begin
                     command_word[15:8] = b;
                     accumulate(b);
                     phase = PH_LEN_LO;
                  end
                  PH_LEN_LO: begin
                     length_word[7:0] = b;
                     accumulate(b);
                     phase = PH_LEN_HI;
                  end
                  PH_LEN_HI: begin
                     length_word[15:8] = b;
                     accumulate(b);
                     if (length_word == '0) phase = PH_SUM_LO;
                     else phase = PH_PAYLOAD;
                  end
                  PH_PAYLOAD: begin
                     r               = '0;
                     r.kind          = KIND_PAYLOAD;
                     r.payload_byte  = b;
                     r.payload_index = byte_count;
                     expected_words.push_back(r);
                     byte_count = byte_count + 1'b1;
                     accumulate(b);
                     if (byte_count == length_word) phase = PH_SUM_LO;
                  end
                  PH_SUM_LO: begin
                     sum_rx[7:0] = b;
                     phase = PH_SUM_HI;
                  end
                  PH_SUM_HI: begin
                     sum_rx[15:8] = b;
                     if (sum_rx != sum_acc) close_frame(ST_CHECKSUM);
                     else phase = PH_CR;
                  end
                  PH_CR: begin
                     if (b != CR_BYTE) close_frame(ST_NO_CR);
                     else phase = PH_LF;
                  end
                  PH_LF: begin
                     if (b != LF_BYTE) close_frame(ST_NO_LF);
                     else close_frame(ST_OK);
                  end
                  default: phase = PH_HUNT;
               endcase
            end
         end
      end
   endtask

   task automatic compare_field(input string field, input logic [WordWidth-1:0] want,
                                input logic [WordWidth-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         limit_reg  = TIMEOUT_RESET;
         id_reg     = DEVICE_ID_RESET;
         item_count = '0;
         armed      = 1'b0;
         clear_frame();
         expected_words.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_TIMEOUT_LIMIT) limit_reg = csr_write_data[CountWidth-1:0];
            else if (csr_index == CSR_DEVICE_ID) id_reg = csr_write_data[ByteWidth-1:0];
         end
         if (req_push && !req_full) advance_parser(req_cmd, req_rx_byte);
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word: kind %0d status %0d", rsp_kind, rsp_status);
               failures++;
            end else begin
               want = expected_words.pop_front();
               compare_field("kind", WordWidth'(want.kind), WordWidth'(rsp_kind));
               compare_field("payload_byte", WordWidth'(want.payload_byte),
                             WordWidth'(rsp_payload_byte));
               compare_field("payload_index", want.payload_index, rsp_payload_index);
               compare_field("status", WordWidth'(want.status), WordWidth'(rsp_status));
               compare_field("frame_command", want.frame_command, rsp_frame_command);
               compare_field("frame_length", want.frame_length, rsp_frame_length);
            end
         end
      end
      outstanding = expected_words.size();
   end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the sensor frame parser: stimulus, receiver, verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfp_pkg::*;

   localparam logic [CmdWidth-1:0] CMD_TICK  = OP_TICK;
   localparam logic [CmdWidth-1:0] CMD_SPARE = 2'd3;   // undefined code, acts as a tick
   localparam int MAX_GAP         = 7;
   localparam int SETTLE_CYCLES   = 6;    // margin for the queues to drain
   localparam int HOLD_OFF_CYCLES = 60;   // long enough to fill both internal queues

   // ways a generated frame can be spoiled
   typedef enum int {
      FLAW_NONE,
      FLAW_SUM,
      FLAW_CR,
      FLAW_LF,
      FLAW_ID,
      FLAW_ZERO
   } flaw_type;

   // one request word as it goes onto the req channel
   typedef struct packed {
      logic [CmdWidth-1:0]  code;
      logic [ByteWidth-1:0] data;
   } line_word_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_push         = 1'b0;
   logic                     req_full;
   logic [CmdWidth-1:0]      req_cmd          = '0;
   logic [ByteWidth-1:0]     req_rx_byte      = '0;
   logic                     rsp_empty;
   logic                     rsp_pop          = 1'b0;
   logic                     rsp_kind;
   logic [ByteWidth-1:0]     rsp_payload_byte;
   logic [WordWidth-1:0]     rsp_payload_index;
   logic [StatusWidth-1:0]   rsp_status;
   logic [WordWidth-1:0]     rsp_frame_command;
   logic [WordWidth-1:0]     rsp_frame_length;
   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index        = '0;
   logic [CsrDataWidth-1:0]  csr_write_data   = '0;

   int outstanding;   // result words predicted but not yet popped
   int failures;

   line_word_type        line_words[$];   // words waiting to be sent
   logic [WordWidth-1:0] frame_sum;       // running checksum of the frame being built
   logic [ByteWidth-1:0] cur_id;          // device ID the block is configured with
   int                   tx_gap_max;
   int                   rx_gap_max;
   int                   tick_pct;        // chance of a tick word before each byte
   int                   hold_cycles;     // receiver hold-off request, consumed once

   sensor_frame_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_rx_byte       (req_rx_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_status        (rsp_status),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   sfp_frame_checker frame_monitor (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_rx_byte       (req_rx_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_status        (rsp_status),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .outstanding       (outstanding),
      .failures          (failures)
   );

   always #5 clock = ~clock;

   // hard stop in case the handshakes hang
   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic add_word(input logic [CmdWidth-1:0] code, input logic [ByteWidth-1:0] data);
      line_word_type w;
      w.code = code;
      w.data = data;
      line_words.push_back(w);
   endtask

   // serial byte, sometimes preceded by an idle tick (either tick code)
   task automatic add_byte(input logic [ByteWidth-1:0] data);
      if ($urandom_range(0, 99) < tick_pct) begin
         if ($urandom_range(0, 1) == 0) add_word(CMD_TICK, ByteWidth'($urandom_range(0, 255)));
         else add_word(CMD_SPARE, ByteWidth'($urandom_range(0, 255)));
      end
      add_word(CMD_BYTE, data);
      frame_sum = frame_sum + {8'h00, data};
   endtask

   // full frame; len_field may disagree with n to push the parser off track
   task automatic add_frame(input logic [ByteWidth-1:0] id, input logic [WordWidth-1:0] command,
                            input logic [WordWidth-1:0] len_field, input int n,
                            input flaw_type flaw);
      logic [WordWidth-1:0] sum;
      logic [ByteWidth-1:0] spoil;
      spoil = ByteWidth'($urandom_range(1, 255));   // nonzero, so a spoiled byte always differs
      add_byte(START_BYTE);
      frame_sum = '0;                   // checksum covers ID through payload
      add_byte((flaw == FLAW_ID) ? id ^ spoil : id);
      add_byte((flaw == FLAW_ZERO) ? spoil : ZERO_BYTE);
      add_byte(command[7:0]);
      add_byte(command[15:8]);
      add_byte(len_field[7:0]);
      add_byte(len_field[15:8]);
      repeat (n) add_byte(ByteWidth'($urandom_range(0, 255)));
      sum = (flaw == FLAW_SUM) ? frame_sum ^ {spoil, spoil} : frame_sum;
      add_byte(sum[7:0]);
      add_byte(sum[15:8]);
      add_byte((flaw == FLAW_CR) ? CR_BYTE ^ spoil : CR_BYTE);
      add_byte((flaw == FLAW_LF) ? LF_BYTE ^ spoil : LF_BYTE);
   endtask

   // push every queued word; entered and left at a falling edge
   task automatic send_stream();
      line_word_type w;
      int            gap;
      while (line_words.size() != 0) begin
         w   = line_words.pop_front();
         gap = $urandom_range(0, tx_gap_max);
         if (gap > 0) begin
            req_push = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_push    = 1'b1;
         req_cmd     = w.code;
         req_rx_byte = w.data;
         do @(posedge clock); while (req_full);
         @(negedge clock);
      end
      req_push = 1'b0;
   endtask

   // wait until every predicted word is popped, then let no-result words drain
   task automatic settle();
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // random start-armed sessions, mostly well-formed frames with random content
   task automatic run_sessions(input int target);
      int                   sent;
      int                   roll;
      int                   n;
      logic [WordWidth-1:0] len_field;
      flaw_type             flaw;
      sent = 0;
      while (sent < target) begin
         // some sessions run with no idling on one or both sides
         tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         tick_pct   = ($urandom_range(0, 1) == 0) ? 0 : 10;
         if ($urandom_range(0, 99) < 8) begin
            // stray words outside a session: mostly ignored, or fed to a hunting parser
            repeat ($urandom_range(1, 4))
               add_word(CmdWidth'($urandom_range(CMD_BYTE, CMD_SPARE)),
                        ByteWidth'($urandom_range(0, 255)));
         end else begin
            add_word(CMD_START, ByteWidth'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 2)) add_byte(ByteWidth'($urandom_range(0, 255)));
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            len_field = ($urandom_range(0, 19) == 0) ? WordWidth'($urandom_range(0, 65535))
                                                     : WordWidth'(n);
            roll = $urandom_range(0, 99);
            if (roll < 60) flaw = FLAW_NONE;
            else if (roll < 70) flaw = FLAW_SUM;
            else if (roll < 78) flaw = FLAW_CR;
            else if (roll < 86) flaw = FLAW_LF;
            else if (roll < 93) flaw = FLAW_ID;
            else flaw = FLAW_ZERO;
            add_frame(cur_id, WordWidth'($urandom_range(0, 65535)), len_field, n, flaw);
            sent += line_words.size();
         end
         send_stream();
      end
   endtask

   // receiver: random pop gaps, plus one long hold-off on request
   initial begin : receiver
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_pop = 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         gap = $urandom_range(0, rx_gap_max);
         if (gap > 0) begin
            rsp_pop = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop = 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      tx_gap_max  = MAX_GAP;
      rx_gap_max  = MAX_GAP;
      tick_pct    = 0;
      hold_cycles = 0;
      cur_id      = DEVICE_ID_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed, reset register values (limit 200, ID 1) ---
      // not armed yet: tick and start byte are both ignored
      add_word(CMD_TICK, 8'h00);
      add_word(CMD_BYTE, START_BYTE);
      // a start byte in the ID slot is a bad ID and is not taken as a new start;
      // the frame's own start byte then begins a zero-length frame, command 0xFFFF
      add_word(CMD_START, 8'hFF);
      add_word(CMD_BYTE, START_BYTE);
      add_word(CMD_BYTE, START_BYTE);
      add_frame(cur_id, 16'hFFFF, 16'h0000, 0, FLAW_NONE);
      // undefined code counts as a tick; bad zero byte falls back to hunting
      add_word(CMD_START, 8'h00);
      add_word(CMD_SPARE, 8'hFF);
      add_word(CMD_BYTE, START_BYTE);
      add_word(CMD_BYTE, cur_id);
      add_word(CMD_BYTE, 8'hFF);
      send_stream();
      settle();

      // --- limit 0, ID 0: the second counted word times out ---
      write_reg(CSR_TIMEOUT_LIMIT, '0);
      write_reg(CSR_DEVICE_ID, '0);
      cur_id = '0;
      add_word(CMD_START, 8'h00);
      add_word(CMD_TICK, 8'h00);
      add_word(CMD_TICK, 8'h00);
      send_stream();
      run_sessions(60);
      settle();

      // --- largest limit (never times out), ID 0xFF ---
      write_reg(CSR_TIMEOUT_LIMIT, COUNT_MAX);
      write_reg(CSR_DEVICE_ID, 20'h000FF);
      cur_id = 8'hFF;
      // long payload while the receiver holds off: both queues fill and req_full rises
      hold_cycles = HOLD_OFF_CYCLES;
      tx_gap_max  = 0;
      tick_pct    = 0;
      add_word(CMD_START, 8'h00);
      add_frame(cur_id, WordWidth'($urandom_range(0, 65535)), 16'd24, 24, FLAW_NONE);
      send_stream();
      run_sessions(400);
      settle();

      // --- tight limit so longer frames time out mid-way; ID equal to the start byte ---
      write_reg(CSR_TIMEOUT_LIMIT, 20'd25);
      write_reg(CSR_DEVICE_ID, CsrDataWidth'(START_BYTE));
      cur_id = START_BYTE;
      run_sessions(350);
      settle();

      // --- random limit and ID; upper data bits of the ID write are dropped ---
      csr_write_data = CsrDataWidth'($urandom());
      write_reg(CSR_TIMEOUT_LIMIT, CsrDataWidth'($urandom_range(30, 400)));
      cur_id = ByteWidth'($urandom_range(0, 255));
      write_reg(CSR_DEVICE_ID, {12'($urandom_range(0, 4095)), cur_id});
      run_sessions(450);
      settle();

      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
